// File: rtl/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants of the heightmap normal stream.
// ----------------------------------------------------------------------------
`default_nettype none

package hns_pkg;

  localparam int unsigned HGT_W   = 16;  // height sample width
  localparam int unsigned POS_W   = 6;   // row / column width
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned QUO_W   = 15;  // quotient bits of each divide
  localparam int unsigned SQRT_N  = 27;  // result bits of the root
  localparam int unsigned SLOPE_W = 26;
  localparam int unsigned RAD_W   = 54;  // radicand width
  localparam int unsigned ODATA_W = 64;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;

  // neighbour read order
  localparam logic [2:0] NB_C = 3'd0;
  localparam logic [2:0] NB_L = 3'd1;
  localparam logic [2:0] NB_R = 3'd2;
  localparam logic [2:0] NB_D = 3'd3;
  localparam logic [2:0] NB_U = 3'd4;

  // multiplier sequence steps
  localparam logic [2:0] MS_ABS  = 3'd0;
  localparam logic [2:0] MS_GX   = 3'd1;
  localparam logic [2:0] MS_GZ   = 3'd2;
  localparam logic [2:0] MS_SQX  = 3'd3;
  localparam logic [2:0] MS_SQZ  = 3'd4;
  localparam logic [2:0] MS_SUM  = 3'd5;

  typedef struct packed {
    logic             wr_en;
    logic [1:0]       wr_slot;
    logic [POS_W-1:0] wr_col;
    logic [POS_W-1:0] e_row;
    logic [POS_W-1:0] e_col;
    logic [1:0]       e_slot;
    logic             e_last;
    logic             e_flast;
    logic [2:0]       rd_idx;
    logic             cap_en;
    logic [2:0]       cap_idx;
    logic             mul_en;
    logic [2:0]       mul_step;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             push;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/hns_ram.sv
// ----------------------------------------------------------------------------
// hns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 99,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/hns_ctrl.sv
// ----------------------------------------------------------------------------
// hns_ctrl
// Sequencer: grid position, emit plan and datapath command issue.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_ctrl #(
  parameter int unsigned GRID_WIDTH = 33
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            frame_start_i,
  output logic                 in_ready_o,
  output hns_pkg::dp_cmd_t     cmd_o,
  input  wire hns_pkg::dp_sts_t sts_i
);
  import hns_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_WIDTH - 1);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]       slot_q, slot_d, in_slot_q, in_slot_d;
  logic [POS_W-1:0] e_row_q, e_row_d, e_col_q, e_col_d;
  logic [1:0]       e_slot_q, e_slot_d;
  logic             e_last_q, e_last_d, e_flast_q, e_flast_d;
  logic             fphase_q, fphase_d;

  logic             accept;
  logic [POS_W-1:0] r_eff, c_eff;
  logic [1:0]       s_eff;
  logic             flush;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign r_eff      = frame_start_i ? '0 : row_q;
  assign c_eff      = frame_start_i ? '0 : col_q;
  assign s_eff      = frame_start_i ? '0 : slot_q;
  assign flush      = (r_eff == LAST_POS) && (c_eff == LAST_POS);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    slot_d    = slot_q;
    in_slot_d = in_slot_q;
    e_row_d   = e_row_q;
    e_col_d   = e_col_q;
    e_slot_d  = e_slot_q;
    e_last_d  = e_last_q;
    e_flast_d = e_flast_q;
    fphase_d  = fphase_q;

    cmd_o           = '0;
    cmd_o.wr_en     = accept;
    cmd_o.wr_slot   = s_eff;
    cmd_o.wr_col    = c_eff;
    cmd_o.e_row     = e_row_q;
    cmd_o.e_col     = e_col_q;
    cmd_o.e_slot    = e_slot_q;
    cmd_o.e_last    = e_last_q;
    cmd_o.e_flast   = e_flast_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (c_eff == LAST_POS) begin
            col_d = '0;
            if (r_eff == LAST_POS) begin
              row_d  = '0;
              slot_d = '0;
            end else begin
              row_d  = r_eff + 1'b1;
              slot_d = (s_eff == 2'd2) ? 2'd0 : s_eff + 1'b1;
            end
          end else begin
            col_d  = c_eff + 1'b1;
            row_d  = r_eff;
            slot_d = s_eff;
          end
          // row 0 produces nothing; otherwise emit the vertex above
          if (r_eff != '0) begin
            e_row_d   = r_eff - 1'b1;
            e_col_d   = c_eff;
            e_slot_d  = (s_eff == 2'd0) ? 2'd2 : s_eff - 1'b1;
            e_last_d  = !flush;
            e_flast_d = 1'b0;
            fphase_d  = 1'b0;
            in_slot_d = s_eff;
            cnt_d     = '0;
            state_d   = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_idx  = cnt_q[2:0];
        cmd_o.cap_en  = (cnt_q != '0);
        cmd_o.cap_idx = 3'(cnt_q - 1'b1);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(5)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = cnt_q[2:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MS_SUM)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_N - 1)) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_init = (cnt_q == '0);
        cmd_o.div_step = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W)) begin
          cnt_d   = '0;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = sts_i.out_free;
        if (sts_i.out_free) begin
          if (e_last_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            if (fphase_q) begin
              e_col_d   = e_col_q + 1'b1;
              e_last_d  = (e_col_q + 1'b1 == LAST_POS);
              e_flast_d = (e_col_q + 1'b1 == LAST_POS);
            end else begin
              // start flushing the final row
              fphase_d  = 1'b1;
              e_row_d   = LAST_POS;
              e_col_d   = '0;
              e_slot_d  = in_slot_q;
              e_last_d  = 1'b0;
              e_flast_d = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      in_slot_q <= '0;
      e_row_q   <= '0;
      e_col_q   <= '0;
      e_slot_q  <= '0;
      e_last_q  <= 1'b0;
      e_flast_q <= 1'b0;
      fphase_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      slot_q    <= slot_d;
      in_slot_q <= in_slot_d;
      e_row_q   <= e_row_d;
      e_col_q   <= e_col_d;
      e_slot_q  <= e_slot_d;
      e_last_q  <= e_last_d;
      e_flast_q <= e_flast_d;
      fphase_q  <= fphase_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hns_dpath.sv
// ----------------------------------------------------------------------------
// hns_dpath
// Line store, slope multiplier, bit-serial root, dividers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_dpath #(
  parameter int unsigned GRID_WIDTH = 33
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hns_pkg::dp_cmd_t              cmd_i,
  output hns_pkg::dp_sts_t                   sts_o,
  input  wire logic [hns_pkg::HGT_W-1:0]     height_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [hns_pkg::GAIN_W-1:0]    cfg_wdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hns_pkg::ODATA_W-1:0]        out_data_o,
  output logic                               out_last_o,
  output logic                               out_flast_o
);
  import hns_pkg::*;

  localparam int unsigned DEPTH = 3 * GRID_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_WIDTH - 1);

  function automatic logic [AW-1:0] addr_of(input logic [1:0] slot,
                                            input logic [POS_W-1:0] col);
    logic [AW-1:0] base;
    base = (slot == 2'd2) ? AW'(2 * GRID_WIDTH) :
           (slot == 2'd1) ? AW'(GRID_WIDTH) : '0;
    return base + AW'(col);
  endfunction

  logic [GAIN_W-1:0] gain_q;
  logic [AW-1:0]     raddr, waddr;
  logic [HGT_W-1:0]  rdata;
  logic [HGT_W-1:0]  h_c_q, h_l_q, h_r_q, h_d_q, h_u_q;
  logic [1:0]        prev_slot, next_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  assign waddr     = addr_of(cmd_i.wr_slot, cmd_i.wr_col);
  assign prev_slot = (cmd_i.e_slot == 2'd0) ? 2'd2 : cmd_i.e_slot - 1'b1;
  assign next_slot = (cmd_i.e_slot == 2'd2) ? 2'd0 : cmd_i.e_slot + 1'b1;

  // edge neighbours read the vertex itself
  always_comb begin
    raddr = addr_of(cmd_i.e_slot, cmd_i.e_col);
    case (cmd_i.rd_idx)
      NB_L: if (cmd_i.e_col != '0)
              raddr = addr_of(cmd_i.e_slot, cmd_i.e_col - 1'b1);
      NB_R: if (cmd_i.e_col != LAST_POS)
              raddr = addr_of(cmd_i.e_slot, cmd_i.e_col + 1'b1);
      NB_D: if (cmd_i.e_row != '0)
              raddr = addr_of(prev_slot, cmd_i.e_col);
      NB_U: if (cmd_i.e_row != LAST_POS)
              raddr = addr_of(next_slot, cmd_i.e_col);
      default: ;
    endcase
  end

  hns_ram #(
    .WIDTH (HGT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (height_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      case (cmd_i.cap_idx)
        NB_C:    h_c_q <= rdata;
        NB_L:    h_l_q <= rdata;
        NB_R:    h_r_q <= rdata;
        NB_D:    h_d_q <= rdata;
        default: h_u_q <= rdata;
      endcase
    end
  end

  // slope and square sequence on one multiplier
  logic [16:0]          dx, dz;
  logic [15:0]          adx_q, adz_q;
  logic                 ngx_q, ngz_q;
  logic [SLOPE_W-1:0]   sx_q, sz_q, op_a, op_b;
  logic [2*SLOPE_W-1:0] prod_q, acc_q;
  logic [RAD_W-1:0]     v_q, res_q, bit_q;
  logic [RAD_W:0]       trial;

  assign dx = {h_l_q[HGT_W-1], h_l_q} - {h_r_q[HGT_W-1], h_r_q};
  assign dz = {h_d_q[HGT_W-1], h_d_q} - {h_u_q[HGT_W-1], h_u_q};

  always_comb begin
    op_a = SLOPE_W'(adx_q);
    op_b = SLOPE_W'(gain_q);
    case (cmd_i.mul_step)
      MS_GZ:   op_a = SLOPE_W'(adz_q);
      MS_SQX: begin
        op_a = sx_q;
        op_b = sx_q;
      end
      MS_SQZ: begin
        op_a = sz_q;
        op_b = sz_q;
      end
      default: ;
    endcase
  end

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        MS_ABS: begin
          ngx_q <= dx[16];
          ngz_q <= dz[16];
          adx_q <= dx[16] ? 16'(-dx) : dx[15:0];
          adz_q <= dz[16] ? 16'(-dz) : dz[15:0];
        end
        MS_GX:  prod_q <= op_a * op_b;
        MS_GZ: begin
          sx_q   <= prod_q[31:6];
          prod_q <= op_a * op_b;
        end
        MS_SQX: begin
          sz_q   <= prod_q[31:6];
          prod_q <= op_a * op_b;
        end
        MS_SQZ: begin
          acc_q  <= prod_q;
          prod_q <= op_a * op_b;
        end
        MS_SUM: begin
          v_q   <= RAD_W'(acc_q) + RAD_W'(prod_q) + (RAD_W'(1) << 32);
          res_q <= '0;
          bit_q <= RAD_W'(1) << 52;
        end
        default: ;
      endcase
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, v_q} >= trial) begin
        v_q   <= RAD_W'({1'b0, v_q} - trial);
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // three restoring dividers sharing the root as divisor
  logic [SQRT_N-1:0] rem_x_q, rem_y_q, rem_z_q;
  logic [QUO_W-1:0]  lo_x_q, lo_y_q, lo_z_q;
  logic [QUO_W-1:0]  q_x_q, q_y_q, q_z_q;
  logic [SQRT_N:0]   t_x, t_y, t_z, dvs;

  assign dvs = {1'b0, res_q[SQRT_N-1:0]};
  assign t_x = {rem_x_q, lo_x_q[QUO_W-1]};
  assign t_y = {rem_y_q, lo_y_q[QUO_W-1]};
  assign t_z = {rem_z_q, lo_z_q[QUO_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_x_q <= SQRT_N'(sx_q >> 1);
      rem_z_q <= SQRT_N'(sz_q >> 1);
      rem_y_q <= SQRT_N'(1) << 15;
      lo_x_q  <= {sx_q[0], 14'd0};
      lo_z_q  <= {sz_q[0], 14'd0};
      lo_y_q  <= '0;
      q_x_q   <= '0;
      q_y_q   <= '0;
      q_z_q   <= '0;
    end else if (cmd_i.div_step) begin
      lo_x_q <= lo_x_q << 1;
      lo_y_q <= lo_y_q << 1;
      lo_z_q <= lo_z_q << 1;
      rem_x_q <= (t_x >= dvs) ? SQRT_N'(t_x - dvs) : t_x[SQRT_N-1:0];
      rem_y_q <= (t_y >= dvs) ? SQRT_N'(t_y - dvs) : t_y[SQRT_N-1:0];
      rem_z_q <= (t_z >= dvs) ? SQRT_N'(t_z - dvs) : t_z[SQRT_N-1:0];
      q_x_q  <= {q_x_q[QUO_W-2:0], t_x >= dvs};
      q_y_q  <= {q_y_q[QUO_W-2:0], t_y >= dvs};
      q_z_q  <= {q_z_q[QUO_W-2:0], t_z >= dvs};
    end
  end

  // output register
  logic        out_valid_q;
  logic [15:0] nx, nz;

  assign nx = (ngx_q && q_x_q != '0) ? 16'(-{1'b0, q_x_q}) : {1'b0, q_x_q};
  assign nz = (ngz_q && q_z_q != '0) ? 16'(-{1'b0, q_z_q}) : {1'b0, q_z_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_o  <= {5'd0, cmd_i.e_row, cmd_i.e_col, nz, q_y_q, nx};
      out_last_o  <= cmd_i.e_last;
      out_flast_o <= cmd_i.e_flast;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: rtl/heightmap_normal_stream.sv
// ----------------------------------------------------------------------------
// heightmap_normal_stream
// Streaming central-difference unit normals of a square height grid.
// ----------------------------------------------------------------------------
// Heights arrive in row-major order; the normal of vertex (r-1,c) comes out
// when sample (r,c) is taken, and the frame's last sample also flushes the
// final row, so that request yields GRID_WIDTH+1 normals. Row-0 samples emit
// no normal. Every normal passes through 5 line-store reads, the shared
// slope/square multiplier, a 27-step bit-serial square root and three
// 15-step restoring dividers in parallel; the root dominates. A new sample
// is taken only once the previous one's normals are produced. The result
// register lets a waiting normal sit while the next sample is taken. No
// line-store clearing pass is done.
`default_nettype none

module heightmap_normal_stream #(
  parameter int unsigned GRID_WIDTH = 33
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // height[15:0]
  input  wire logic        s_axis_tuser_i,   // frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // normal_x[15:0], normal_y[30:16], normal_z[46:31], column[52:47],
  // row[58:53], zero[63:59]
  output logic [63:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,   // run_last
  output logic             m_axis_tuser_o,   // frame_last
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i      // slope_gain
);
  import hns_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hns_ctrl #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .frame_start_i (s_axis_tuser_i),
    .in_ready_o    (s_axis_tready_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  hns_dpath #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .height_i    (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_flast_o (m_axis_tuser_o)
  );

  // final vertex normal closes its request
  a_flast_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("frame_last without run_last");

  a_flast_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[52:47] == POS_W'(GRID_WIDTH - 1)) &&
      (m_axis_tdata_o[58:53] == POS_W'(GRID_WIDTH - 1)))
    else $error("frame_last on wrong vertex");

  // y component never vanishes: root is bounded by 2^27
  a_ny_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[30:16] != '0))
    else $error("normal_y is zero");

  // a push only happens when the result register can take it
  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free)
    else $error("result overwritten");

endmodule

`default_nettype wire
